// ===== rtl/core/crbf_pkg.sv =====
// Package for the credit-reserved batch FIFO: operation and status codes,
// configuration register indexes, fixed widths and the sequencer state type.
// Depends on nothing; credit_reserved_batch_fifo imports it.
package crbf_pkg;

  // Operation codes carried by the opcode field.
  localparam logic [2:0] OP_RESERVE       = 3'd0;
  localparam logic [2:0] OP_QUERY         = 3'd1;
  localparam logic [2:0] OP_PUSH_RESERVED = 3'd2;
  localparam logic [2:0] OP_PUSH_UNBOUND  = 3'd3;
  localparam logic [2:0] OP_POP_BATCH     = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOCAP = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_CAPACITY    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BATCH_KEY_LIMIT = 1'd1;

  // Field and accumulator widths fixed by the interface.
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned KEY_FIELD_W   = 16;
  localparam int unsigned PAYLOAD_FIELD_W = 64;
  localparam int unsigned TAKEN_OUT_W   = 21;
  localparam int unsigned TOTAL_W       = 40;
  // Taken keys stay below the 32-bit limit until the last add of a batch.
  localparam int unsigned TAKEN_W       = CFG_W + 1;

  localparam logic [CFG_W-1:0] KEY_CAPACITY_RESET    = 32'd1024;
  localparam logic [CFG_W-1:0] BATCH_KEY_LIMIT_RESET = 32'd256;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

endpackage

// ===== rtl/core/crbf_store.sv =====
// Entry storage of the credit-reserved batch FIFO: payload and key arrays
// with one write port and one registered read port.
// Depends on nothing outside this file.
module crbf_store #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned PAYLOAD_W = 64,
  parameter int unsigned KEY_W     = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [PAYLOAD_W-1:0]     wr_payload,
  input  logic [KEY_W-1:0]         wr_keys,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [PAYLOAD_W-1:0]     rd_payload,
  output logic [KEY_W-1:0]         rd_keys
);

  logic [PAYLOAD_W-1:0] payload_mem [DEPTH];
  logic [KEY_W-1:0]     key_mem     [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_mem[wr_addr] <= wr_payload;
      key_mem[wr_addr]     <= wr_keys;
    end
  end

  // Read-before-write: a read of the entry being written returns old data.
  always_ff @(posedge clk) begin
    rd_payload <= payload_mem[rd_addr];
    rd_keys    <= key_mem[rd_addr];
  end

endmodule

// ===== rtl/core/credit_reserved_batch_fifo.sv =====
// Top level of the credit-reserved batch FIFO: admission control, FIFO
// pointers, the batch-pop sequencer and the output register.
// Depends on crbf_pkg and crbf_store.

// Usage notes. The block keeps a FIFO of payload words, each tagged with a
// key count, and a 40-bit reserved-key total used for admission. Reserve,
// query and both push operations each produce one result beat. A batch pop
// first starts, which issues the first read of the entry memory through its
// single registered read port, and then delivers one item beat per cycle
// while out_stall is low. A pop of an empty FIFO, or with a batch limit of
// zero, answers with a single beat. The block works on one input at a time:
// while a pop is streaming, in_stall stays high. A result beat waits in the
// output register while out_stall is high, and the next input is accepted in
// the same cycle the waiting beat is taken. Configuration registers may be
// written whenever the block is idle.
module credit_reserved_batch_fifo #(
  parameter int unsigned FIFO_DEPTH    = 32,
  parameter int unsigned PAYLOAD_WIDTH = 64,
  parameter int unsigned KEY_WIDTH     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_write,
  input  logic [crbf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [crbf_pkg::CFG_W-1:0]        cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        opcode,
  input  logic [crbf_pkg::KEY_FIELD_W-1:0]  item_keys,
  input  logic                              allow_oversized,
  input  logic [crbf_pkg::PAYLOAD_FIELD_W-1:0] item_payload,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic                              item_valid,
  output logic [crbf_pkg::PAYLOAD_FIELD_W-1:0] out_payload,
  output logic [crbf_pkg::KEY_FIELD_W-1:0]  out_keys,
  output logic [crbf_pkg::TAKEN_OUT_W-1:0]  taken_keys,
  output logic                              last
);

  import crbf_pkg::*;

  // Keys are limited both by the 16-bit field and by KEY_WIDTH.
  localparam int unsigned KW    = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int unsigned PW    = PAYLOAD_WIDTH;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  // Control state.
  state_t             state, state_next;
  logic [PTR_W-1:0]   read_pointer, read_pointer_next;
  logic [PTR_W-1:0]   write_pointer, write_pointer_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [TOTAL_W-1:0] reserved_total, reserved_total_next;
  logic [TAKEN_W-1:0] taken, taken_next;
  logic [CFG_W-1:0]   key_capacity, batch_key_limit;
  logic               out_valid_next;

  // Result beat being loaded into the output register.
  logic               load;
  logic [1:0]         status_next;
  logic               item_valid_next;
  logic [PAYLOAD_FIELD_W-1:0] out_payload_next;
  logic [KEY_FIELD_W-1:0]     out_keys_next;
  logic [TAKEN_OUT_W-1:0]     taken_keys_next;
  logic               last_next;

  // Memory ports.
  logic               wr_en;
  logic [PTR_W-1:0]   rd_addr;
  logic [PW-1:0]      rd_payload;
  logic [KW-1:0]      rd_keys;

  // Datapath helpers.
  logic               out_free, accept, pop_fire, fifo_full, more;
  logic [KW-1:0]      keys_in;
  logic [CFG_W-1:0]   keys_cfg, room;
  logic               fits;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_sat, taken_total;
  logic [TAKEN_W-1:0] taken_sum;
  logic [CNT_W-1:0]   count_dec;
  logic [PTR_W-1:0]   read_pointer_inc, write_pointer_inc;

  crbf_store #(
    .DEPTH     (FIFO_DEPTH),
    .PAYLOAD_W (PW),
    .KEY_W     (KW)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (write_pointer),
    .wr_payload (item_payload[PW-1:0]),
    .wr_keys    (keys_in),
    .rd_addr    (rd_addr),
    .rd_payload (rd_payload),
    .rd_keys    (rd_keys)
  );

  // The output register is free when empty or when its beat leaves now.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign pop_fire = (state == S_POP) && out_free;

  assign fifo_full = (entry_count == CNT_W'(FIFO_DEPTH));
  assign read_pointer_inc  = (read_pointer == PTR_W'(FIFO_DEPTH - 1)) ?
                             '0 : read_pointer + 1'b1;
  assign write_pointer_inc = (write_pointer == PTR_W'(FIFO_DEPTH - 1)) ?
                             '0 : write_pointer + 1'b1;

  // Admission test: an item above the capacity only gets in alone, and
  // only when allowed; otherwise the total must fit under capacity - keys.
  assign keys_in  = item_keys[KW-1:0];
  assign keys_cfg = CFG_W'(keys_in);
  assign room     = key_capacity - keys_cfg;
  assign fits     = (keys_cfg > key_capacity) ?
                    (allow_oversized && (reserved_total == '0)) :
                    (reserved_total <= TOTAL_W'(room));

  // Saturating add of the item's keys to the reserved total.
  assign total_sum = {1'b0, reserved_total} + (TOTAL_W + 1)'(keys_in);
  assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  // Pop step: the entry at read_pointer was read in the previous cycle.
  // The same address is read again every cycle the beat is stalled, so the
  // read data stays valid. No push can land while a pop streams, and a push
  // accepted just before a pop is written before the pop's first read.
  assign taken_sum   = taken + TAKEN_W'(rd_keys);
  assign count_dec   = entry_count - 1'b1;
  assign more        = (count_dec != '0) && (taken_sum < TAKEN_W'(batch_key_limit));
  assign taken_total = TOTAL_W'(taken_sum);
  assign rd_addr     = pop_fire ? read_pointer_inc : read_pointer;

  always_comb begin
    state_next          = state;
    read_pointer_next   = read_pointer;
    write_pointer_next  = write_pointer;
    entry_count_next    = entry_count;
    reserved_total_next = reserved_total;
    taken_next          = taken;
    wr_en               = 1'b0;
    load                = 1'b0;
    status_next         = ST_OK;
    item_valid_next     = 1'b0;
    out_payload_next    = '0;
    out_keys_next       = '0;
    taken_keys_next     = '0;
    last_next           = 1'b1;

    if (accept) begin
      load = 1'b1;
      case (opcode)
        OP_RESERVE: begin
          if (fits) begin
            reserved_total_next = total_sat;
          end else begin
            status_next = ST_NOCAP;
          end
        end
        OP_QUERY: begin
          status_next = fits ? ST_OK : ST_NOCAP;
        end
        OP_PUSH_RESERVED, OP_PUSH_UNBOUND: begin
          if (fifo_full) begin
            status_next = ST_FULL;
          end else begin
            wr_en              = 1'b1;
            write_pointer_next = write_pointer_inc;
            entry_count_next   = entry_count + 1'b1;
            if (opcode == OP_PUSH_UNBOUND) begin
              reserved_total_next = total_sat;
            end
          end
        end
        OP_POP_BATCH: begin
          if (entry_count == '0) begin
            status_next = ST_EMPTY;
          end else if (batch_key_limit != '0) begin
            // The batch streams from the next cycle on.
            load       = 1'b0;
            taken_next = '0;
            state_next = S_POP;
          end
        end
        default: begin
          // Unknown operations answer ok and change nothing.
        end
      endcase
    end

    if (pop_fire) begin
      load                                 = 1'b1;
      item_valid_next                      = 1'b1;
      out_payload_next[PW-1:0]             = rd_payload;
      out_keys_next[KW-1:0]                = rd_keys;
      taken_keys_next                      = taken_sum[TAKEN_OUT_W-1:0];
      last_next                            = !more;
      read_pointer_next                    = read_pointer_inc;
      entry_count_next                     = count_dec;
      taken_next                           = taken_sum;
      if (!more) begin
        state_next          = S_IDLE;
        reserved_total_next = (reserved_total > taken_total) ?
                              reserved_total - taken_total : '0;
      end
    end

    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_free) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      read_pointer    <= '0;
      write_pointer   <= '0;
      entry_count     <= '0;
      reserved_total  <= '0;
      taken           <= '0;
      out_valid       <= 1'b0;
      key_capacity    <= KEY_CAPACITY_RESET;
      batch_key_limit <= BATCH_KEY_LIMIT_RESET;
    end else begin
      state          <= state_next;
      read_pointer   <= read_pointer_next;
      write_pointer  <= write_pointer_next;
      entry_count    <= entry_count_next;
      reserved_total <= reserved_total_next;
      taken          <= taken_next;
      out_valid      <= out_valid_next;
      if (cfg_write && (cfg_index == CFG_KEY_CAPACITY)) begin
        key_capacity <= cfg_data;
      end
      if (cfg_write && (cfg_index == CFG_BATCH_KEY_LIMIT)) begin
        batch_key_limit <= cfg_data;
      end
    end
  end

  // Result payload registers need no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      status      <= status_next;
      item_valid  <= item_valid_next;
      out_payload <= out_payload_next;
      out_keys    <= out_keys_next;
      taken_keys  <= taken_keys_next;
      last        <= last_next;
    end
  end

endmodule
